// ===== src/mmps_pkg.sv =====
// shared types, constants and microcode program of the motor plant step
`default_nettype none

package mmps_pkg;

	localparam int TQ_W       = 32;
	localparam int GAIN_W     = 31;
	localparam int POS_W      = 48;
	localparam int FRAC_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam int STEP_W     = 3;

	localparam int STICTION_BAND = 64;
	localparam int ACCEL_LIMIT   = 1048576;
	localparam int DT_SHIFT      = 0;

	localparam logic [CFG_IDX_W-1:0] REG_VISCOUS_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STATIC_FRIC   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COULOMB_FRIC  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TORQUE_LIMIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_GAIN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_VEL_LIMIT     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_POS_MIN       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_POS_MAX       = 3'd7;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_TORQUE,
		OP_FRICTION,
		OP_NET,
		OP_SUM,
		OP_ACCEL,
		OP_VELOCITY,
		OP_POSITION
	} op_t;

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_FRICTION,
		MUL_ACCEL
	} mul_t;

	typedef enum logic [1:0] {
		CND_NEXT,
		CND_NO_REQ,
		CND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t               op;
		mul_t              mul;
		cond_t             cond;
		logic [STEP_W-1:0] target;
	} ucode_t;

	typedef struct packed {
		logic req_valid;
		logic out_free;
	} seq_status_t;

	typedef struct packed {
		op_t  op;
		mul_t mul;
		logic wait_req;
		logic fire;
	} seq_ctrl_t;

	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t uc;
		unique case (step)
			3'd0:    uc = '{OP_TORQUE,   MUL_FRICTION, CND_NO_REQ,   3'd0};
			3'd1:    uc = '{OP_FRICTION, MUL_NONE,     CND_NEXT,     3'd0};
			3'd2:    uc = '{OP_NET,      MUL_NONE,     CND_NEXT,     3'd0};
			3'd3:    uc = '{OP_NOP,      MUL_ACCEL,    CND_NEXT,     3'd0};
			3'd4:    uc = '{OP_SUM,      MUL_NONE,     CND_NEXT,     3'd0};
			3'd5:    uc = '{OP_ACCEL,    MUL_NONE,     CND_NEXT,     3'd0};
			3'd6:    uc = '{OP_VELOCITY, MUL_NONE,     CND_NEXT,     3'd0};
			3'd7:    uc = '{OP_POSITION, MUL_NONE,     CND_OUT_BUSY, 3'd7};
			default: uc = '{OP_NOP,      MUL_NONE,     CND_NEXT,     3'd0};
		endcase
		return uc;
	endfunction

endpackage

`default_nettype wire

// ===== src/mmps_in_if.sv =====
// request channel carrying one plant tick
`default_nettype none

interface mmps_in_if;
	logic                             valid;
	logic                             ready;
	logic signed [mmps_pkg::TQ_W-1:0] commanded_torque;
	logic signed [mmps_pkg::TQ_W-1:0] load_torque;

	modport source (output valid, output commanded_torque, output load_torque, input ready);
	modport sink (input valid, input commanded_torque, input load_torque, output ready);
endinterface

`default_nettype wire

// ===== src/mmps_out_if.sv =====
// result channel carrying one plant step result
`default_nettype none

interface mmps_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [mmps_pkg::TQ_W-1:0]  applied_torque;
	logic signed [mmps_pkg::TQ_W-1:0]  friction_out;
	logic signed [mmps_pkg::TQ_W-1:0]  accel_out;
	logic signed [mmps_pkg::TQ_W-1:0]  velocity_out;
	logic signed [mmps_pkg::POS_W-1:0] position_out;
	logic                              at_stop;

	modport source (
		output valid, output applied_torque, output friction_out, output accel_out,
		output velocity_out, output position_out, output at_stop, input ready
	);
	modport sink (
		input valid, input applied_torque, input friction_out, input accel_out,
		input velocity_out, input position_out, input at_stop, output ready
	);
endinterface

`default_nettype wire

// ===== src/mmps_seq.sv =====
// microcode sequencer: step counter, control store and conditional jumps
`default_nettype none

module mmps_seq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mmps_pkg::seq_status_t  status,
	output mmps_pkg::seq_ctrl_t    ctrl
);
	import mmps_pkg::*;

	logic [STEP_W-1:0] step_q;
	ucode_t            uc;
	logic              hold;

	always_comb begin
		uc = ucode_rom(step_q);
		unique case (uc.cond)
			CND_NEXT:     hold = 1'b0;
			CND_NO_REQ:   hold = !status.req_valid;
			CND_OUT_BUSY: hold = !status.out_free;
			default:      hold = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (hold) begin
			step_q <= uc.target;
		end else begin
			step_q <= step_q + STEP_W'(1);
		end
	end

	assign ctrl.op       = uc.op;
	assign ctrl.mul      = uc.mul;
	assign ctrl.wait_req = (uc.cond == CND_NO_REQ);
	assign ctrl.fire     = !hold;

endmodule

`default_nettype wire

// ===== src/motor_mechanical_plant_step.sv =====
// top level: configuration registers, plant datapath and result register
// flow: a request is accepted at step 0 and the result register loads at step 7
// a new request is taken only after the eight-step microcode program has run through,
// with its single shared 33x32 multiplier; the result register lets the next request
// run while a result waits, and the last step stalls only while an older result is held
// reset: velocity and position clear to zero, registers take their reset values, no result
`default_nettype none

module motor_mechanical_plant_step (
	input  logic                              clk,
	input  logic                              arst_n,
	mmps_in_if.sink                           tick,
	mmps_out_if.source                        result,
	input  logic                              wr_en,
	input  logic [mmps_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [mmps_pkg::CFG_DATA_W-1:0]   wr_data
);
	import mmps_pkg::*;

	localparam int NET_W   = TQ_W + 2;
	localparam int MUL_A_W = TQ_W + 1;
	localparam int MUL_B_W = TQ_W;
	localparam int MUL_W   = MUL_A_W + MUL_B_W;
	localparam int VISC_W  = TQ_W + GAIN_W - FRAC_W;
	localparam int FRIC_W  = VISC_W + 1;
	localparam int SUM_W   = 2 * TQ_W;
	localparam int AMAG_W  = SUM_W - FRAC_W;

	localparam logic [GAIN_W-1:0]        GAIN_ONE  = GAIN_W'(65536);
	localparam logic signed [POS_W-1:0]  POS_LO    = {1'b1, {(POS_W-1){1'b0}}};
	localparam logic signed [POS_W-1:0]  POS_HI    = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [FRIC_W-1:0] TQ_MAX_X  =
		{{(FRIC_W-TQ_W+1){1'b0}}, {(TQ_W-1){1'b1}}};
	localparam logic signed [FRIC_W-1:0] TQ_MIN_X  =
		{{(FRIC_W-TQ_W+1){1'b1}}, {(TQ_W-1){1'b0}}};
	localparam logic [AMAG_W-1:0]        ACC_LIM_X = AMAG_W'(ACCEL_LIMIT);
	localparam logic signed [TQ_W-1:0]   ACC_HI    = TQ_W'(ACCEL_LIMIT);
	localparam logic signed [TQ_W-1:0]   ACC_LO    = -ACC_HI;

	// configuration
	logic [GAIN_W-1:0]        visc_gain_q, stat_fric_q, coul_fric_q;
	logic [GAIN_W-1:0]        torque_lim_q, accel_gain_q, vel_lim_q;
	logic signed [POS_W-1:0]  pos_min_q, pos_max_q;

	// plant state
	logic signed [TQ_W-1:0]   vel_q;
	logic signed [POS_W-1:0]  pos_q;

	// working registers
	logic signed [TQ_W-1:0]   load_q, applied_q, fric_q, inc_q, nv_q;
	logic signed [NET_W-1:0]  net_q;
	logic signed [MUL_W-1:0]  mul_q;
	logic [SUM_W-1:0]         sum_q;

	// result register
	logic                     out_valid_q;
	logic signed [TQ_W-1:0]   o_applied_q, o_fric_q, o_accel_q, o_vel_q;
	logic signed [POS_W-1:0]  o_pos_q;
	logic                     o_stop_q;

	seq_status_t              status;
	seq_ctrl_t                ctrl;
	logic                     out_free;
	logic                     commit;

	logic signed [TQ_W:0]     cmd_x, tq_lim_s, tq_lim_n;
	logic signed [TQ_W-1:0]   applied_nx;
	logic signed [VISC_W-1:0] visc_s;
	logic signed [FRIC_W-1:0] visc_x, fmag_x, fric_sum;
	logic [TQ_W:0]            vel_x, vel_abs;
	logic [GAIN_W-1:0]        fmag;
	logic signed [TQ_W-1:0]   fric_nx;
	logic signed [NET_W-1:0]  net_nx, net_abs_full;
	logic                     net_neg;
	logic [NET_W-2:0]         net_mag;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic [SUM_W-1:0]         sum_add;
	logic [AMAG_W-1:0]        acc_mag;
	logic [TQ_W-1:0]          acc_lim;
	logic signed [TQ_W-1:0]   accel_s, inc_nx;
	logic signed [TQ_W:0]     vsum, vl_s, vl_n;
	logic signed [TQ_W-1:0]   nv_nx, nv_sh, nv_fin;
	logic signed [POS_W:0]    np_raw, pmin_x, pmax_x;
	logic signed [POS_W-1:0]  np_fin;
	logic                     stop;

	mmps_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	assign out_free         = !out_valid_q || result.ready;
	assign status.req_valid = tick.valid;
	assign status.out_free  = out_free;
	assign tick.ready       = ctrl.wait_req;
	assign commit           = ctrl.fire && (ctrl.op == OP_POSITION);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visc_gain_q  <= '0;
			stat_fric_q  <= '0;
			coul_fric_q  <= '0;
			torque_lim_q <= '1;
			accel_gain_q <= GAIN_ONE;
			vel_lim_q    <= '1;
			pos_min_q    <= POS_LO;
			pos_max_q    <= POS_HI;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_VISCOUS_GAIN: visc_gain_q  <= wr_data[GAIN_W-1:0];
				REG_STATIC_FRIC:  stat_fric_q  <= wr_data[GAIN_W-1:0];
				REG_COULOMB_FRIC: coul_fric_q  <= wr_data[GAIN_W-1:0];
				REG_TORQUE_LIMIT: torque_lim_q <= wr_data[GAIN_W-1:0];
				REG_ACCEL_GAIN:   accel_gain_q <= wr_data[GAIN_W-1:0];
				REG_VEL_LIMIT:    vel_lim_q    <= wr_data[GAIN_W-1:0];
				REG_POS_MIN:      pos_min_q    <= $signed(wr_data[POS_W-1:0]);
				REG_POS_MAX:      pos_max_q    <= $signed(wr_data[POS_W-1:0]);
				default: ;
			endcase
		end
	end

	// torque clamp, taken straight from the request
	always_comb begin
		cmd_x    = {tick.commanded_torque[TQ_W-1], tick.commanded_torque};
		tq_lim_s = $signed({2'b00, torque_lim_q});
		tq_lim_n = -tq_lim_s;
		if (cmd_x > tq_lim_s) begin
			applied_nx = tq_lim_s[TQ_W-1:0];
		end else if (cmd_x < tq_lim_n) begin
			applied_nx = tq_lim_n[TQ_W-1:0];
		end else begin
			applied_nx = cmd_x[TQ_W-1:0];
		end
	end

	// friction from the stored velocity
	always_comb begin
		visc_s  = $signed(mul_q[TQ_W+GAIN_W-1:FRAC_W]);
		visc_x  = {visc_s[VISC_W-1], visc_s};
		vel_x   = {vel_q[TQ_W-1], vel_q};
		vel_abs = vel_q[TQ_W-1] ? -vel_x : vel_x;
		fmag    = (vel_abs < (TQ_W+1)'(STICTION_BAND)) ? stat_fric_q : coul_fric_q;
		fmag_x  = $signed({{(FRIC_W-GAIN_W){1'b0}}, fmag});
		fric_sum = visc_x + (vel_q[TQ_W-1] ? -fmag_x : fmag_x);
		if (fric_sum > TQ_MAX_X) begin
			fric_nx = TQ_MAX_X[TQ_W-1:0];
		end else if (fric_sum < TQ_MIN_X) begin
			fric_nx = TQ_MIN_X[TQ_W-1:0];
		end else begin
			fric_nx = fric_sum[TQ_W-1:0];
		end
	end

	// net torque and its magnitude
	always_comb begin
		net_nx = {{2{applied_q[TQ_W-1]}}, applied_q} - {{2{fric_q[TQ_W-1]}}, fric_q}
			- {{2{load_q[TQ_W-1]}}, load_q};
		net_neg      = net_q[NET_W-1];
		net_abs_full = net_neg ? -net_q : net_q;
		net_mag      = net_abs_full[NET_W-2:0];
	end

	// shared multiplier operands
	always_comb begin
		unique case (ctrl.mul)
			MUL_FRICTION: begin
				mul_a = {vel_q[TQ_W-1], vel_q};
				mul_b = $signed({1'b0, visc_gain_q});
			end
			MUL_ACCEL: begin
				mul_a = $signed({1'b0, net_mag[TQ_W-1:0]});
				mul_b = $signed({1'b0, accel_gain_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// top bit of the magnitude and the rounding bias fold into one add
	always_comb begin
		sum_add = {1'b0, (net_mag[NET_W-2] ? accel_gain_q : {GAIN_W{1'b0}}),
			{(TQ_W-FRAC_W){1'b0}}, (net_neg ? {FRAC_W{1'b1}} : {FRAC_W{1'b0}})};
		acc_mag = sum_q[SUM_W-1:FRAC_W];
		acc_lim = (acc_mag > ACC_LIM_X) ? ACC_LIM_X[TQ_W-1:0] : acc_mag[TQ_W-1:0];
		accel_s = net_neg ? -$signed(acc_lim) : $signed(acc_lim);
		inc_nx  = accel_s >>> DT_SHIFT;
	end

	// velocity integration
	always_comb begin
		vsum = {vel_q[TQ_W-1], vel_q} + {inc_q[TQ_W-1], inc_q};
		vl_s = $signed({2'b00, vel_lim_q});
		vl_n = -vl_s;
		if (vsum > vl_s) begin
			nv_nx = vl_s[TQ_W-1:0];
		end else if (vsum < vl_n) begin
			nv_nx = vl_n[TQ_W-1:0];
		end else begin
			nv_nx = vsum[TQ_W-1:0];
		end
	end

	// position integration and hard stops
	always_comb begin
		nv_sh  = nv_q >>> DT_SHIFT;
		np_raw = {pos_q[POS_W-1], pos_q} + {{(POS_W+1-TQ_W){nv_sh[TQ_W-1]}}, nv_sh};
		pmin_x = {pos_min_q[POS_W-1], pos_min_q};
		pmax_x = {pos_max_q[POS_W-1], pos_max_q};
		nv_fin = nv_q;
		stop   = 1'b0;
		priority if (np_raw > pmax_x) begin
			np_fin = pos_max_q;
			stop   = 1'b1;
			if (nv_q > 0) begin
				nv_fin = '0;
			end
		end else if (np_raw < pmin_x) begin
			np_fin = pos_min_q;
			stop   = 1'b1;
			if (nv_q < 0) begin
				nv_fin = '0;
			end
		end else begin
			np_fin = np_raw[POS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fire && (ctrl.mul != MUL_NONE)) begin
			mul_q <= mul_a * mul_b;
		end
		if (ctrl.fire) begin
			unique case (ctrl.op)
				OP_NOP: ;
				OP_TORQUE: begin
					applied_q <= applied_nx;
					load_q    <= tick.load_torque;
				end
				OP_FRICTION: fric_q <= fric_nx;
				OP_NET:      net_q  <= net_nx;
				OP_SUM:      sum_q  <= mul_q[SUM_W-1:0] + sum_add;
				OP_ACCEL:    inc_q  <= inc_nx;
				OP_VELOCITY: nv_q   <= nv_nx;
				OP_POSITION: begin
					o_applied_q <= applied_q;
					o_fric_q    <= fric_q;
					o_accel_q   <= inc_q;
					o_vel_q     <= nv_fin;
					o_pos_q     <= np_fin;
					o_stop_q    <= stop;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (commit) begin
			vel_q       <= nv_fin;
			pos_q       <= np_fin;
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.applied_torque = o_applied_q;
	assign result.friction_out   = o_fric_q;
	assign result.accel_out      = o_accel_q;
	assign result.velocity_out   = o_vel_q;
	assign result.position_out   = o_pos_q;
	assign result.at_stop        = o_stop_q;

	a_commit_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> result.valid)
		else $error("step result not presented after commit");

	a_stop_on_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.at_stop) |->
			((result.position_out == pos_min_q) || (result.position_out == pos_max_q)))
		else $error("hard stop flagged away from a stop position");

	a_velocity_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |->
			(($signed({result.velocity_out[TQ_W-1], result.velocity_out}) <= vl_s) &&
			 ($signed({result.velocity_out[TQ_W-1], result.velocity_out}) >= vl_n)))
		else $error("velocity beyond its limit");

	a_accel_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ((result.accel_out <= ACC_HI) && (result.accel_out >= ACC_LO)))
		else $error("velocity increment beyond its limit");

endmodule

`default_nettype wire

// ===== verif/mmps_plant_check_pkg.sv =====
// plant step scoreboard: fixed-point plant predictor and in-order result check
`timescale 1ns / 100ps

package mmps_plant_check_pkg;
	import mmps_pkg::*;

	typedef struct {
		logic signed [TQ_W-1:0]  applied_torque;
		logic signed [TQ_W-1:0]  friction_out;
		logic signed [TQ_W-1:0]  accel_out;
		logic signed [TQ_W-1:0]  velocity_out;
		logic signed [POS_W-1:0] position_out;
		logic                    at_stop;
	} plant_step_t;

	class plant_scoreboard;
		logic [GAIN_W-1:0]       viscous_gain;
		logic [GAIN_W-1:0]       static_fric;
		logic [GAIN_W-1:0]       coulomb_fric;
		logic [GAIN_W-1:0]       torque_limit;
		logic [GAIN_W-1:0]       accel_gain;
		logic [GAIN_W-1:0]       vel_limit;
		logic signed [POS_W-1:0] pos_min;
		logic signed [POS_W-1:0] pos_max;
		logic signed [TQ_W-1:0]  velocity;
		logic signed [POS_W-1:0] position;
		plant_step_t             expected_steps[$];
		int                      errors;
		int                      ticks;
		int                      steps;
		int                      stop_hits;
		int                      band_hits;

		function new();
			viscous_gain = '0;
			static_fric  = '0;
			coulomb_fric = '0;
			torque_limit = '1;
			accel_gain   = GAIN_W'(1 << FRAC_W);
			vel_limit    = '1;
			pos_min      = {1'b1, {(POS_W-1){1'b0}}};
			pos_max      = {1'b0, {(POS_W-1){1'b1}}};
			velocity     = '0;
			position     = '0;
			errors       = 0;
			ticks        = 0;
			steps        = 0;
			stop_hits    = 0;
			band_hits    = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_VISCOUS_GAIN: viscous_gain = data[GAIN_W-1:0];
				REG_STATIC_FRIC:  static_fric  = data[GAIN_W-1:0];
				REG_COULOMB_FRIC: coulomb_fric = data[GAIN_W-1:0];
				REG_TORQUE_LIMIT: torque_limit = data[GAIN_W-1:0];
				REG_ACCEL_GAIN:   accel_gain   = data[GAIN_W-1:0];
				REG_VEL_LIMIT:    vel_limit    = data[GAIN_W-1:0];
				REG_POS_MIN:      pos_min      = data[POS_W-1:0];
				REG_POS_MAX:      pos_max      = data[POS_W-1:0];
				default: ;
			endcase
		endfunction

		static function longint limit_to(longint x, longint lo, longint hi);
			if (x > hi)
				return hi;
			if (x < lo)
				return lo;
			return x;
		endfunction

		function plant_step_t advance_plant(logic signed [TQ_W-1:0] cmd,
				logic signed [TQ_W-1:0] load);
			plant_step_t      s;
			longint           v;
			longint           tl;
			longint           applied;
			longint           fric;
			longint           mag;
			longint           abs_v;
			longint           net;
			longint           accel;
			longint           nv;
			longint           np;
			longint unsigned  net_mag;
			longint unsigned  prod;
			logic             neg;
			logic             stop;

			v  = velocity;
			tl = longint'(torque_limit);
			applied = limit_to(longint'(cmd), -tl, tl);

			// friction from the stored velocity
			abs_v = (v < 0) ? -v : v;
			if (v != 0 && abs_v < STICTION_BAND)
				band_hits++;
			fric = (v * longint'(viscous_gain)) >>> FRAC_W;
			mag  = (abs_v < STICTION_BAND) ? longint'(static_fric) : longint'(coulomb_fric);
			fric = (v >= 0) ? fric + mag : fric - mag;
			fric = limit_to(fric, -(longint'(1) << 31), (longint'(1) << 31) - 1);

			// exact magnitude product, rounded toward minus infinity
			net     = applied - fric - longint'(load);
			neg     = net < 0;
			net_mag = neg ? -net : net;
			prod    = net_mag * longint'(accel_gain);
			accel   = neg ? -longint'((prod + 64'hFFFF) >> FRAC_W) : longint'(prod >> FRAC_W);
			accel   = limit_to(accel, -longint'(ACCEL_LIMIT), longint'(ACCEL_LIMIT));
			accel   = accel >>> DT_SHIFT;

			nv = limit_to(v + accel, -longint'(vel_limit), longint'(vel_limit));
			np = longint'(position) + (nv >>> DT_SHIFT);
			stop = 1'b0;
			if (np > longint'(pos_max)) begin
				np = pos_max;
				stop = 1'b1;
				if (nv > 0)
					nv = 0;
			end else if (np < longint'(pos_min)) begin
				np = pos_min;
				stop = 1'b1;
				if (nv < 0)
					nv = 0;
			end
			if (stop)
				stop_hits++;

			velocity = TQ_W'(nv);
			position = POS_W'(np);

			s.applied_torque = TQ_W'(applied);
			s.friction_out   = TQ_W'(fric);
			s.accel_out      = TQ_W'(accel);
			s.velocity_out   = TQ_W'(nv);
			s.position_out   = POS_W'(np);
			s.at_stop        = stop;
			return s;
		endfunction

		function void note_tick(logic signed [TQ_W-1:0] cmd, logic signed [TQ_W-1:0] load);
			ticks++;
			expected_steps.push_back(advance_plant(cmd, load));
		endfunction

		function int pending();
			return expected_steps.size();
		endfunction

		function void compare_field(string name, logic signed [63:0] want,
				logic signed [63:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			end
		endfunction

		function void check_step(plant_step_t got);
			plant_step_t want;

			steps++;
			if (expected_steps.size() == 0) begin
				errors++;
				$display("%0t: result with no request pending, expected none got position %0d",
					$time, got.position_out);
				return;
			end
			want = expected_steps.pop_front();
			compare_field("applied_torque", want.applied_torque, got.applied_torque);
			compare_field("friction_out", want.friction_out, got.friction_out);
			compare_field("accel_out", want.accel_out, got.accel_out);
			compare_field("velocity_out", want.velocity_out, got.velocity_out);
			compare_field("position_out", want.position_out, got.position_out);
			compare_field("at_stop", {63'b0, want.at_stop}, {63'b0, got.at_stop});
		endfunction
	endclass

endpackage

// ===== verif/tb_motor_mechanical_plant_step.sv =====
// testbench top: drives plant ticks and register settings, checks every step result
`timescale 1ns / 100ps

module tb_motor_mechanical_plant_step;
	import mmps_pkg::*;
	import mmps_plant_check_pkg::*;

	localparam int STALL_LIMIT     = 2000;
	localparam int DRAIN_CYCLES    = 12;
	localparam int RANDOM_PHASES   = 12;
	localparam int TICKS_PER_PHASE = 100;

	localparam logic signed [TQ_W-1:0] T_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [TQ_W-1:0] T_MIN = 32'sh8000_0000;
	localparam logic [GAIN_W-1:0]      GAIN_MAX = 31'h7FFF_FFFF;
	localparam logic [GAIN_W-1:0]      Q_ONE = 31'h0001_0000;
	localparam logic [POS_W-1:0]       POS_LOWEST = 48'h8000_0000_0000;
	localparam logic [POS_W-1:0]       POS_HIGHEST = 48'h7FFF_FFFF_FFFF;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;
	logic                  calm;
	int                    idle_cycles = 0;
	logic [CFG_DATA_W-1:0] cfg_word [8];
	plant_scoreboard       sb;

	mmps_in_if  tick_if ();
	mmps_out_if result_if ();

	motor_mechanical_plant_step dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick_if),
		.result   (result_if),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #5 clk = ~clk;

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 5);
	endfunction

	function automatic logic signed [TQ_W-1:0] pick_torque(int scale);
		case ($urandom_range(0, 9))
			0: return T_MAX;
			1: return T_MIN;
			2, 3: return $urandom;
			4: return $signed($urandom) >>> 24;
			default: return $signed($urandom) >>> (31 - scale);
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain(int unsigned typical_hi);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return GAIN_MAX;
			2, 3: return GAIN_W'($urandom);
			default: return GAIN_W'($urandom_range(0, typical_hi));
		endcase
	endfunction

	function automatic void reset_words();
		cfg_word[REG_VISCOUS_GAIN] = '0;
		cfg_word[REG_STATIC_FRIC]  = '0;
		cfg_word[REG_COULOMB_FRIC] = '0;
		cfg_word[REG_TORQUE_LIMIT] = CFG_DATA_W'(GAIN_MAX);
		cfg_word[REG_ACCEL_GAIN]   = CFG_DATA_W'(Q_ONE);
		cfg_word[REG_VEL_LIMIT]    = CFG_DATA_W'(GAIN_MAX);
		cfg_word[REG_POS_MIN]      = POS_LOWEST;
		cfg_word[REG_POS_MAX]      = POS_HIGHEST;
	endfunction

	function automatic void draw_config(int phase);
		if (phase == 0) begin
			for (int i = REG_VISCOUS_GAIN; i <= REG_VEL_LIMIT; i++)
				cfg_word[i] = {17'($urandom), GAIN_MAX};
			cfg_word[REG_POS_MIN] = POS_LOWEST;
			cfg_word[REG_POS_MAX] = POS_HIGHEST;
		end else if (phase == 1) begin
			for (int i = REG_VISCOUS_GAIN; i <= REG_VEL_LIMIT; i++)
				cfg_word[i] = {17'($urandom), {GAIN_W{1'b0}}};
			cfg_word[REG_POS_MIN] = '0;
			cfg_word[REG_POS_MAX] = '0;
		end else begin
			cfg_word[REG_VISCOUS_GAIN] = {17'($urandom), pick_gain(1 << 14)};
			cfg_word[REG_STATIC_FRIC]  = {17'($urandom), pick_gain(1 << 18)};
			cfg_word[REG_COULOMB_FRIC] = {17'($urandom), pick_gain(1 << 18)};
			cfg_word[REG_TORQUE_LIMIT] = {17'($urandom), pick_gain(1 << 21)};
			cfg_word[REG_ACCEL_GAIN]   = {17'($urandom), pick_gain(1 << 17)};
			cfg_word[REG_VEL_LIMIT]    = {17'($urandom),
				pick_gain($urandom_range(0, 1) ? 128 : (1 << 22))};
			case ($urandom_range(0, 5))
				0: begin
					cfg_word[REG_POS_MIN] = POS_LOWEST;
					cfg_word[REG_POS_MAX] = POS_HIGHEST;
				end
				1, 2: begin
					cfg_word[REG_POS_MIN] = -CFG_DATA_W'($urandom_range(0, 1 << 28));
					cfg_word[REG_POS_MAX] = CFG_DATA_W'($urandom_range(0, 1 << 28));
				end
				3: begin
					// crossed stops
					cfg_word[REG_POS_MIN] = CFG_DATA_W'($urandom_range(0, 1 << 24));
					cfg_word[REG_POS_MAX] = -CFG_DATA_W'($urandom_range(0, 1 << 24));
				end
				4: begin
					cfg_word[REG_POS_MIN] = CFG_DATA_W'({$urandom, $urandom});
					cfg_word[REG_POS_MAX] = CFG_DATA_W'({$urandom, $urandom});
				end
				default: begin
					cfg_word[REG_POS_MIN] = -CFG_DATA_W'($urandom_range(0, 1 << 20));
					cfg_word[REG_POS_MAX] = CFG_DATA_W'($urandom_range(0, 1 << 20));
				end
			endcase
		end
	endfunction

	task automatic load_config();
		for (int i = 0; i < 8; i++) begin
			wr_en    <= 1'b1;
			wr_index <= CFG_IDX_W'(i);
			wr_data  <= cfg_word[i];
			sb.write_reg(CFG_IDX_W'(i), cfg_word[i]);
			@(negedge clk);
		end
		wr_en <= 1'b0;
	endtask

	task automatic send_tick(input logic signed [TQ_W-1:0] cmd,
			input logic signed [TQ_W-1:0] load);
		int gap;

		gap = draw_gap();
		if (gap > 0) begin
			tick_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		tick_if.valid            <= 1'b1;
		tick_if.commanded_torque <= cmd;
		tick_if.load_torque      <= load;
		@(posedge clk);
		while (!tick_if.ready)
			@(posedge clk);
		sb.note_tick(cmd, load);
		@(negedge clk);
	endtask

	task automatic settle();
		tick_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// result side
	initial begin
		plant_step_t got;
		int          stall;

		result_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				result_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_if.ready <= 1'b1;
			@(posedge clk);
			while (!result_if.valid)
				@(posedge clk);
			got.applied_torque = result_if.applied_torque;
			got.friction_out   = result_if.friction_out;
			got.accel_out      = result_if.accel_out;
			got.velocity_out   = result_if.velocity_out;
			got.position_out   = result_if.position_out;
			got.at_stop        = result_if.at_stop;
			sb.check_step(got);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (tick_if.valid && tick_if.ready) || (result_if.valid && result_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no request or result moved for %0d cycles", $time, idle_cycles);
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		sb = new();
		calm                     = 1'b0;
		arst_n                   = 1'b0;
		wr_en                    = 1'b0;
		wr_index                 = '0;
		wr_data                  = '0;
		tick_if.valid            = 1'b0;
		tick_if.commanded_torque = '0;
		tick_if.load_torque      = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings, torque and load extremes
		send_tick(T_MAX, 32'sd0);
		send_tick(T_MIN, 32'sd0);
		send_tick(32'sd0, T_MAX);
		send_tick(32'sd0, T_MIN);
		send_tick(T_MIN, T_MAX);
		send_tick(T_MAX, T_MIN);
		settle();

		// drive into the upper stop, then back into the lower stop
		reset_words();
		cfg_word[REG_VISCOUS_GAIN] = CFG_DATA_W'(Q_ONE);
		cfg_word[REG_STATIC_FRIC]  = 48'h8000;
		cfg_word[REG_COULOMB_FRIC] = 48'h4000;
		cfg_word[REG_TORQUE_LIMIT] = 48'h4_0000;
		cfg_word[REG_VEL_LIMIT]    = 48'h20_0000;
		cfg_word[REG_POS_MIN]      = -(48'd8 << FRAC_W);
		cfg_word[REG_POS_MAX]      = 48'd8 << FRAC_W;
		load_config();
		repeat (4) send_tick(T_MAX, 32'sd0);
		repeat (6) send_tick(T_MIN, 32'sd0);
		settle();

		// crossed stops
		reset_words();
		cfg_word[REG_POS_MIN] = 48'd16 << FRAC_W;
		cfg_word[REG_POS_MAX] = -(48'd16 << FRAC_W);
		load_config();
		send_tick(32'sd0, 32'sd0);
		send_tick(32'sd1, 32'sd0);
		settle();

		// velocity held inside the stiction band
		reset_words();
		cfg_word[REG_VISCOUS_GAIN] = CFG_DATA_W'(GAIN_MAX);
		cfg_word[REG_STATIC_FRIC]  = 48'h100;
		cfg_word[REG_COULOMB_FRIC] = CFG_DATA_W'(GAIN_MAX);
		cfg_word[REG_VEL_LIMIT]    = 48'd40;
		load_config();
		send_tick(32'sd1000, 32'sd0);
		send_tick(32'sd1000, 32'sd0);
		send_tick(-32'sd1000, 32'sd0);
		send_tick(32'sd0, 32'sd0);
		settle();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			draw_config(phase);
			load_config();
			calm = (phase % 4 == 2);
			repeat (TICKS_PER_PHASE) send_tick(pick_torque(20), pick_torque(17));
			settle();
		end

		$display("covered %0d plant ticks over %0d register settings, %0d results checked",
			sb.ticks, RANDOM_PHASES + 4, sb.steps);
		$display("hard stop steps %0d, steps inside the stiction band %0d, mismatches %0d",
			sb.stop_hits, sb.band_hits, sb.errors);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
